/* rtl/sweep_sync_lock_detector_unit_assert.svh */
// Assertion macros for the sweep sync lock detector.
// Expects clk and rst_n in the scope of the module that uses them.
`ifndef SWEEP_SYNC_LOCK_DETECTOR_UNIT_ASSERT_SVH
`define SWEEP_SYNC_LOCK_DETECTOR_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define SSLOCK_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset
`define SSLOCK_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/sslock_pkg.sv */
// Shared types, constants and register map for the sweep sync lock detector.
// Used by sslock_decode, sslock_regs and the top level; no dependencies.
package sslock_pkg;

  // Field widths
  localparam int TIME_W  = 32;
  localparam int LEN_W   = 16;
  localparam int WIN_W   = 20;
  localparam int TOL_W   = 9;
  localparam int CODE_W  = 3;
  localparam int PHASE_W = 3;
  localparam int SLOT_W  = 12;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 5;
  localparam int IDX_W   = ADDR_W - 2;

  // Pulse length slots
  localparam int SLOT_TICKS = 500;
  localparam int MAX_CODE   = 7;
  localparam logic [LEN_W-1:0] CODE_SPAN = LEN_W'(SLOT_TICKS * (MAX_CODE + 1));

  // Code bits and the patterns the sequence expects (data bit ignored)
  localparam logic [CODE_W-1:0] MATCH_MASK = 3'b101;
  localparam logic [CODE_W-1:0] MATCH_NONE = 3'b000;
  localparam logic [CODE_W-1:0] MATCH_SKIP = 3'b100;
  localparam logic [CODE_W-1:0] MATCH_AXIS = 3'b001;
  localparam logic [CODE_W-1:0] MATCH_BOTH = 3'b101;

  // Phase codes
  localparam logic [PHASE_W-1:0] PH_SEARCH    = 3'd0;
  localparam logic [PHASE_W-1:0] PH_WAIT_SKIP = 3'd1;
  localparam logic [PHASE_W-1:0] PH_WAIT_AXIS = 3'd2;
  localparam logic [PHASE_W-1:0] PH_WAIT_BOTH = 3'd3;
  localparam logic [PHASE_W-1:0] PH_LOCKED    = 3'd4;

  // Register indexes (byte address = 4 * index)
  localparam logic [IDX_W-1:0] REG_SHORT_MIN = 3'd0;
  localparam logic [IDX_W-1:0] REG_SHORT_MAX = 3'd1;
  localparam logic [IDX_W-1:0] REG_LONG_MIN  = 3'd2;
  localparam logic [IDX_W-1:0] REG_LONG_MAX  = 3'd3;
  localparam logic [IDX_W-1:0] REG_LEN_BASE  = 3'd4;
  localparam logic [IDX_W-1:0] REG_SLOT_TOL  = 3'd5;

  // Register reset values
  localparam logic [WIN_W-1:0] RST_SHORT_MIN = 20'd18720;
  localparam logic [WIN_W-1:0] RST_SHORT_MAX = 20'd21600;
  localparam logic [WIN_W-1:0] RST_LONG_MIN  = 20'd398832;
  localparam logic [WIN_W-1:0] RST_LONG_MAX  = 20'd401136;
  localparam logic [LEN_W-1:0] RST_LEN_BASE  = 16'd2880;
  localparam logic [TOL_W-1:0] RST_SLOT_TOL  = 9'd150;

  typedef struct packed {
    logic [TIME_W-1:0] pulse_time;
    logic [LEN_W-1:0]  pulse_length;
  } in_word_t;

  typedef struct packed {
    logic [PHASE_W-1:0] lock_phase;
    logic               is_locked;
    logic [CODE_W-1:0]  pulse_code;
    logic               code_valid;
  } out_word_t;

  typedef struct packed {
    logic [WIN_W-1:0] short_min;
    logic [WIN_W-1:0] short_max;
    logic [WIN_W-1:0] long_min;
    logic [WIN_W-1:0] long_max;
    logic [LEN_W-1:0] length_base;
    logic [TOL_W-1:0] slot_tol;
  } cfg_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              valid;
  } decode_t;

  // Start offset of each code's slot
  function automatic logic [SLOT_W-1:0] slot_start(input logic [CODE_W-1:0] code);
    logic [SLOT_W-1:0] start;
    case (code)
      3'd0:    start = 12'd0;
      3'd1:    start = 12'd500;
      3'd2:    start = 12'd1000;
      3'd3:    start = 12'd1500;
      3'd4:    start = 12'd2000;
      3'd5:    start = 12'd2500;
      3'd6:    start = 12'd3000;
      default: start = 12'd3500;
    endcase
    return start;
  endfunction

endpackage

/* rtl/sslock_decode.sv */
// Pulse length to code decoder for the sweep sync lock detector.
// Depends on sslock_pkg.
module sslock_decode (
  input  logic [sslock_pkg::LEN_W-1:0] pulse_length,
  input  logic [sslock_pkg::LEN_W-1:0] length_base,
  input  logic [sslock_pkg::TOL_W-1:0] slot_tol,
  output sslock_pkg::decode_t          dec
);
  import sslock_pkg::*;

  logic [LEN_W-1:0]  off;
  logic              above_base;
  logic              in_span;
  logic [CODE_W-1:0] slot;
  logic [SLOT_W-1:0] rem;
  logic              in_tol;

  // Offset from the base; the slot count only matters below the span
  assign above_base = (pulse_length >= length_base);
  assign off        = pulse_length - length_base;
  assign in_span    = (off < CODE_SPAN);

  // Find the slot by comparing against every slot start
  always_comb begin
    slot = '0;
    for (int k = 1; k <= MAX_CODE; k++) begin
      if (off >= LEN_W'(slot_start(CODE_W'(k)))) begin
        slot = CODE_W'(k);
      end
    end
  end

  // Remainder within the slot must sit below the tolerance
  assign rem    = off[SLOT_W-1:0] - slot_start(slot);
  assign in_tol = (rem < SLOT_W'(slot_tol));

  assign dec.valid = above_base & in_span & in_tol;
  assign dec.code  = dec.valid ? slot : '0;

endmodule

/* rtl/sslock_regs.sv */
// Configuration register file with an APB-style write and read port.
// Depends on sslock_pkg.
module sslock_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sslock_pkg::ADDR_W-1:0] paddr,
  input  logic [sslock_pkg::DATA_W-1:0] pwdata,
  output logic [sslock_pkg::DATA_W-1:0] prdata,
  output sslock_pkg::cfg_t              cfg
);
  import sslock_pkg::*;

  cfg_t             cfg_r;
  cfg_t             cfg_nxt;
  logic             wr_en;
  logic [IDX_W-1:0] idx;

  assign idx   = paddr[ADDR_W-1:2];
  assign wr_en = psel & penable & pwrite;

  // Decode the write
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_SHORT_MIN: cfg_nxt.short_min   = pwdata[WIN_W-1:0];
        REG_SHORT_MAX: cfg_nxt.short_max   = pwdata[WIN_W-1:0];
        REG_LONG_MIN:  cfg_nxt.long_min    = pwdata[WIN_W-1:0];
        REG_LONG_MAX:  cfg_nxt.long_max    = pwdata[WIN_W-1:0];
        REG_LEN_BASE:  cfg_nxt.length_base = pwdata[LEN_W-1:0];
        REG_SLOT_TOL:  cfg_nxt.slot_tol    = pwdata[TOL_W-1:0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  // Hold the registers, load defaults on reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.short_min   <= RST_SHORT_MIN;
      cfg_r.short_max   <= RST_SHORT_MAX;
      cfg_r.long_min    <= RST_LONG_MIN;
      cfg_r.long_max    <= RST_LONG_MAX;
      cfg_r.length_base <= RST_LEN_BASE;
      cfg_r.slot_tol    <= RST_SLOT_TOL;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Read back, zero-extended
  always_comb begin
    unique case (idx)
      REG_SHORT_MIN: prdata = DATA_W'(cfg_r.short_min);
      REG_SHORT_MAX: prdata = DATA_W'(cfg_r.short_max);
      REG_LONG_MIN:  prdata = DATA_W'(cfg_r.long_min);
      REG_LONG_MAX:  prdata = DATA_W'(cfg_r.long_max);
      REG_LEN_BASE:  prdata = DATA_W'(cfg_r.length_base);
      REG_SLOT_TOL:  prdata = DATA_W'(cfg_r.slot_tol);
      default:       prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

/* rtl/sweep_sync_lock_detector_unit.sv */
// Sweep sync lock detector.
// Input channel (in_valid / in_stall / in_word): one word per optical sync
// pulse, with its timestamp and measured length. A word is taken at a clock
// edge where in_valid is high and in_stall is low.
// Result channel (out_valid / out_stall / out_word): one word per pulse, with
// the decoded code, its validity and the lock phase after that pulse.
// The word sits in the input register, then decode, window compares and phase
// update land in the output register, which drives out_valid. Throughput is
// one pulse per cycle while out_stall is low; the phase and reference time
// update in the cycle the pulse moves to the output.
// When out_stall is high with a word waiting, the input register still takes
// one more word; after that in_stall rises until the output is taken.
// Reset (rst_n low, synchronous) empties both registers, returns the phase to
// searching, clears the reference time and reloads the default windows,
// length base and slot tolerance.
// Configuration goes through the APB-style port at byte address 4 * index;
// write it only while no pulse is in flight. pready is always high.
// Depends on sslock_pkg, sslock_decode, sslock_regs and the assertion header.
`include "sweep_sync_lock_detector_unit_assert.svh"

module sweep_sync_lock_detector_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  sslock_pkg::in_word_t          in_word,
  output logic                          out_valid,
  input  logic                          out_stall,
  output sslock_pkg::out_word_t         out_word,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sslock_pkg::ADDR_W-1:0] paddr,
  input  logic [sslock_pkg::DATA_W-1:0] pwdata,
  output logic [sslock_pkg::DATA_W-1:0] prdata,
  output logic                          pready
);
  import sslock_pkg::*;

  cfg_t               cfg;
  decode_t            dec;

  logic               in_valid_r;
  logic               in_valid_nxt;
  in_word_t           in_word_r;
  logic               out_valid_r;
  logic               out_valid_nxt;
  out_word_t          out_word_r;
  out_word_t          out_word_nxt;
  logic [PHASE_W-1:0] phase_r;
  logic [PHASE_W-1:0] phase_nxt;
  logic [TIME_W-1:0]  ref_time_r;
  logic [TIME_W-1:0]  ref_time_nxt;

  logic               in_take;
  logic               out_open;
  logic               advance;
  logic [TIME_W-1:0]  diff;
  logic [WIN_W-1:0]   win_min;
  logic [WIN_W-1:0]   win_max;
  logic               early;
  logic               late;
  logic [CODE_W-1:0]  masked;

  // Configuration registers
  sslock_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );
  assign pready = 1'b1;

  // Handshake: advance when the output register is empty or being drained
  assign out_open      = !out_valid_r || !out_stall;
  assign advance       = in_valid_r && out_open;
  assign in_stall      = in_valid_r && !out_open;
  assign in_take       = in_valid && !in_stall;
  assign in_valid_nxt  = in_take || (in_valid_r && !advance);
  assign out_valid_nxt = advance || (out_valid_r && out_stall);

  // Decode the pulse length
  sslock_decode u_decode (
    .pulse_length (in_word_r.pulse_length),
    .length_base  (cfg.length_base),
    .slot_tol     (cfg.slot_tol),
    .dec          (dec)
  );

  // Elapsed time against the window of the current phase
  assign diff    = in_word_r.pulse_time - ref_time_r;
  assign win_min = (phase_r == PH_WAIT_AXIS) ? cfg.long_min : cfg.short_min;
  assign win_max = (phase_r == PH_WAIT_AXIS) ? cfg.long_max : cfg.short_max;
  assign early   = (diff < TIME_W'(win_min));
  assign late    = (diff > TIME_W'(win_max));
  assign masked  = dec.code & MATCH_MASK;

  // Phase sequencer
  always_comb begin
    phase_nxt    = phase_r;
    ref_time_nxt = ref_time_r;
    unique case (phase_r)
      PH_SEARCH: begin
        if (dec.valid && masked == MATCH_NONE) begin
          phase_nxt    = PH_WAIT_SKIP;
          ref_time_nxt = in_word_r.pulse_time;
        end
      end
      PH_WAIT_SKIP: begin
        if (!early) begin
          if (late) begin
            phase_nxt = PH_SEARCH;
          end else if (dec.valid && masked == MATCH_SKIP) begin
            phase_nxt = PH_WAIT_AXIS;
          end
        end
      end
      PH_WAIT_AXIS: begin
        if (!early) begin
          if (late) begin
            phase_nxt = PH_SEARCH;
          end else if (dec.valid && masked == MATCH_AXIS) begin
            phase_nxt    = PH_WAIT_BOTH;
            ref_time_nxt = in_word_r.pulse_time;
          end
        end
      end
      PH_WAIT_BOTH: begin
        if (!early) begin
          if (late) begin
            phase_nxt = PH_SEARCH;
          end else if (dec.valid && masked == MATCH_BOTH) begin
            phase_nxt = PH_LOCKED;
          end
        end
      end
      default: begin
        phase_nxt = phase_r;
      end
    endcase
  end

  // Assemble the result word
  always_comb begin
    out_word_nxt.lock_phase = phase_nxt;
    out_word_nxt.is_locked  = (phase_nxt == PH_LOCKED);
    out_word_nxt.pulse_code = dec.code;
    out_word_nxt.code_valid = dec.valid;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      phase_r     <= PH_SEARCH;
      ref_time_r  <= '0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (advance) begin
        phase_r    <= phase_nxt;
        ref_time_r <= ref_time_nxt;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_word_r <= in_word;
    end
    if (advance) begin
      out_word_r <= out_word_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // Checks
  `SSLOCK_ASSERT_NXT(a_lock_holds, phase_r == PH_LOCKED, phase_r == PH_LOCKED,
    "lock phase was left without reset")
  `SSLOCK_ASSERT_NXT(a_phase_idle, !advance, $stable(phase_r) && $stable(ref_time_r),
    "phase state moved without a pulse")
  `SSLOCK_ASSERT_IMP(a_phase_range, 1'b1, phase_r <= PH_LOCKED,
    "phase outside the sequence")
  `SSLOCK_ASSERT_IMP(a_code_zero, out_valid_r && !out_word_r.code_valid,
    out_word_r.pulse_code == '0, "invalid pulse reported a nonzero code")

endmodule

/* sim/sslock_result_monitor.sv */
// Result monitor for the sweep sync lock detector: watches the pulse, result
// and register channels, predicts each result word and compares it.
// Depends on sslock_pkg for the word types, phase codes and register map.
`timescale 1ns / 1ps

module sslock_result_monitor (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  sslock_pkg::in_word_t          in_word,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  sslock_pkg::out_word_t         out_word,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic                          pready,
  input  logic [sslock_pkg::ADDR_W-1:0] paddr,
  input  logic [sslock_pkg::DATA_W-1:0] pwdata,
  output int                            fail_count,
  output int                            pending_count
);
  import sslock_pkg::*;

  // Shadow copy of the detector's registers and sequence state
  cfg_t               cfg_q;
  logic [PHASE_W-1:0] phase_q;
  logic [TIME_W-1:0]  ref_time_q;

  out_word_t   lock_words_due[$];
  int          fails = 0;
  int          due_count = 0;
  int unsigned results_seen = 0;

  assign fail_count    = fails;
  assign pending_count = due_count;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at result word %0d: %s", results_seen, msg);
    fails++;
  endtask

  task automatic check_field(input string name, input int unsigned got,
                             input int unsigned exp);
    if (got != exp)
      report_mismatch($sformatf("%s is %0d, expected %0d", name, got, exp));
  endtask

  // Decode the length, step the phase machine, build the result word
  task automatic predict_lock_word(input in_word_t w, output out_word_t r);
    logic [LEN_W-1:0]  off;
    logic [TIME_W-1:0] diff;
    logic [CODE_W-1:0] code;
    logic [CODE_W-1:0] masked;
    int unsigned       slot;
    bit                valid;
    code  = '0;
    valid = 1'b0;
    if (w.pulse_length >= cfg_q.length_base) begin
      off  = w.pulse_length - cfg_q.length_base;
      slot = off / SLOT_TICKS;
      if (slot <= MAX_CODE && (off % SLOT_TICKS) < cfg_q.slot_tol) begin
        valid = 1'b1;
        code  = CODE_W'(slot);
      end
    end
    masked = code & MATCH_MASK;
    diff   = w.pulse_time - ref_time_q;
    // An early pulse is ignored, a late one drops back to searching
    case (phase_q)
      PH_SEARCH: begin
        if (valid && masked == MATCH_NONE) begin
          phase_q    = PH_WAIT_SKIP;
          ref_time_q = w.pulse_time;
        end
      end
      PH_WAIT_SKIP: begin
        if (diff >= cfg_q.short_min) begin
          if (diff > cfg_q.short_max) phase_q = PH_SEARCH;
          else if (valid && masked == MATCH_SKIP) phase_q = PH_WAIT_AXIS;
        end
      end
      PH_WAIT_AXIS: begin
        if (diff >= cfg_q.long_min) begin
          if (diff > cfg_q.long_max) begin
            phase_q = PH_SEARCH;
          end else if (valid && masked == MATCH_AXIS) begin
            phase_q    = PH_WAIT_BOTH;
            ref_time_q = w.pulse_time;
          end
        end
      end
      PH_WAIT_BOTH: begin
        if (diff >= cfg_q.short_min) begin
          if (diff > cfg_q.short_max) phase_q = PH_SEARCH;
          else if (valid && masked == MATCH_BOTH) phase_q = PH_LOCKED;
        end
      end
      default: ;
    endcase
    r.lock_phase = phase_q;
    r.is_locked  = (phase_q == PH_LOCKED);
    r.pulse_code = code;
    r.code_valid = valid;
  endtask

  always @(posedge clk) begin
    out_word_t want;
    if (!rst_n) begin
      cfg_q.short_min   = RST_SHORT_MIN;
      cfg_q.short_max   = RST_SHORT_MAX;
      cfg_q.long_min    = RST_LONG_MIN;
      cfg_q.long_max    = RST_LONG_MAX;
      cfg_q.length_base = RST_LEN_BASE;
      cfg_q.slot_tol    = RST_SLOT_TOL;
      phase_q    = PH_SEARCH;
      ref_time_q = '0;
      lock_words_due.delete();
    end else begin
      // Track register writes
      if (psel && penable && pwrite && pready) begin
        case (paddr[ADDR_W-1:2])
          REG_SHORT_MIN: cfg_q.short_min   = pwdata[WIN_W-1:0];
          REG_SHORT_MAX: cfg_q.short_max   = pwdata[WIN_W-1:0];
          REG_LONG_MIN:  cfg_q.long_min    = pwdata[WIN_W-1:0];
          REG_LONG_MAX:  cfg_q.long_max    = pwdata[WIN_W-1:0];
          REG_LEN_BASE:  cfg_q.length_base = pwdata[LEN_W-1:0];
          REG_SLOT_TOL:  cfg_q.slot_tol    = pwdata[TOL_W-1:0];
          default: ;
        endcase
      end
      // Compare each taken result word with the oldest prediction
      if (out_valid && !out_stall) begin
        results_seen++;
        if (lock_words_due.size() == 0) begin
          report_mismatch("result word with no prediction pending");
        end else begin
          want = lock_words_due.pop_front();
          check_field("lock_phase", out_word.lock_phase, want.lock_phase);
          check_field("is_locked", out_word.is_locked, want.is_locked);
          check_field("pulse_code", out_word.pulse_code, want.pulse_code);
          check_field("code_valid", out_word.code_valid, want.code_valid);
        end
      end
      // Predict from each taken pulse word
      if (in_valid && !in_stall) begin
        predict_lock_word(in_word, want);
        lock_words_due.push_back(want);
      end
    end
    due_count <= lock_words_due.size();
  end

endmodule

/* sim/testbench.sv */
// Top of the sweep sync lock detector bench: clock, reset, pulse and register
// stimulus, receiver stalls and the verdict.
// Depends on sslock_pkg, sweep_sync_lock_detector_unit and sslock_result_monitor.
`timescale 1ns / 1ps

module testbench;
  import sslock_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam logic [CODE_W-1:0] DATA_BIT = 3'b010;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  in_word_t          in_word = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  out_word_t         out_word;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  int                fail_count;
  int                pending_count;

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned pulses_sent = 0;
  int unsigned cycle_count = 0;

  // Register values currently in the block, and the running pulse clock
  int unsigned s_min, s_max, l_min, l_max, len_base, slot_tol;
  logic [TIME_W-1:0] cur_t = '0;

  sweep_sync_lock_detector_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  sslock_result_monitor monitor (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_word       (in_word),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_word      (out_word),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .pready        (pready),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Receiver back-pressure
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Hard stop if the run hangs
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic write_reg(input logic [IDX_W-1:0] idx, input int unsigned value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input int unsigned smin, input int unsigned smax,
                            input int unsigned lmin, input int unsigned lmax,
                            input int unsigned base, input int unsigned tol);
    s_min    = smin;
    s_max    = smax;
    l_min    = lmin;
    l_max    = lmax;
    len_base = base;
    slot_tol = tol;
    write_reg(REG_SHORT_MIN, smin);
    write_reg(REG_SHORT_MAX, smax);
    write_reg(REG_LONG_MIN, lmin);
    write_reg(REG_LONG_MAX, lmax);
    write_reg(REG_LEN_BASE, base);
    write_reg(REG_SLOT_TOL, tol);
  endtask

  // Offer one pulse word, idling at random first; hold it until taken
  task automatic send_pulse(input logic [TIME_W-1:0] t, input logic [LEN_W-1:0] len);
    in_word_t w;
    w.pulse_time   = t;
    w.pulse_length = len;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall);
    pulses_sent++;
  endtask

  // Drop valid and wait until every predicted word has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
    repeat (4) @(posedge clk);
  endtask

  // Length that decodes to the code, or one that fails to decode
  function automatic logic [LEN_W-1:0] length_for(input int unsigned code, input bit good);
    int unsigned start;
    start = len_base + code * SLOT_TICKS;
    if (good && slot_tol > 0)
      return LEN_W'(start + $urandom_range(((slot_tol > SLOT_TICKS) ? SLOT_TICKS : slot_tol) - 1));
    if (slot_tol < SLOT_TICKS)
      return LEN_W'(start + $urandom_range(SLOT_TICKS - 1, slot_tol));
    if (len_base > 0)
      return LEN_W'($urandom_range(len_base - 1));
    return LEN_W'($urandom_range(65535, SLOT_TICKS * (MAX_CODE + 1)));
  endfunction

  // Length whose code does not fit the pattern, or does not decode at all
  function automatic logic [LEN_W-1:0] wrong_length(input logic [CODE_W-1:0] pattern);
    logic [CODE_W-1:0] code;
    if ($urandom_range(3) == 0) return length_for($urandom_range(MAX_CODE), 1'b0);
    do code = CODE_W'($urandom_range(MAX_CODE)); while ((code & MATCH_MASK) == pattern);
    return length_for(code, 1'b1);
  endfunction

  function automatic logic [LEN_W-1:0] step_length(input logic [CODE_W-1:0] pattern,
                                                   input bit clean);
    if (!clean && $urandom_range(9) == 0) return wrong_length(pattern);
    // the data bit is free
    return length_for(pattern | ($urandom_range(1) ? DATA_BIT : 3'b000), 1'b1);
  endfunction

  // Gap inside the window, or now and then just past it
  function automatic int unsigned step_gap(input int unsigned lo, input int unsigned hi,
                                           input bit clean);
    if (!clean && $urandom_range(7) == 0) return hi + 1 + $urandom_range(2000);
    if (lo <= hi) return $urandom_range(hi, lo);
    return lo;
  endfunction

  function automatic int unsigned early_gap(input int unsigned lo);
    if (lo == 0) return 0;
    return $urandom_range(lo - 1);
  endfunction

  // One sync sequence with random content; only a clean one may lock
  task automatic run_sync_sequence(input bit clean);
    logic [TIME_W-1:0] t0, t2;
    int unsigned       n;
    // late undecodable word drops any partial sequence back to searching
    cur_t = cur_t + 32'h0020_0000 + $urandom_range(32'h000F_FFFF);
    send_pulse(cur_t, length_for($urandom_range(MAX_CODE), 1'b0));
    t0 = cur_t + $urandom_range(5000, 1);
    send_pulse(t0, step_length(MATCH_NONE, clean));
    n = $urandom_range(2);
    repeat (n) send_pulse(t0 + early_gap(s_min), length_for($urandom_range(MAX_CODE), 1'b1));
    send_pulse(t0 + step_gap(s_min, s_max, clean), step_length(MATCH_SKIP, clean));
    n = $urandom_range(2);
    repeat (n) send_pulse(t0 + early_gap(l_min), length_for($urandom_range(MAX_CODE), 1'b1));
    t2 = t0 + step_gap(l_min, l_max, clean);
    send_pulse(t2, step_length(MATCH_AXIS, clean));
    n = $urandom_range(2);
    repeat (n) send_pulse(t2 + early_gap(s_min), length_for($urandom_range(MAX_CODE), 1'b1));
    cur_t = t2 + step_gap(s_min, s_max, clean);
    send_pulse(cur_t, clean ? step_length(MATCH_BOTH, 1'b1) : wrong_length(MATCH_BOTH));
  endtask

  // Mostly well-formed sequences, the rest raw noise words
  task automatic run_random(input int unsigned count);
    int unsigned stop_at;
    stop_at = pulses_sent + count;
    while (pulses_sent < stop_at) begin
      if ($urandom_range(4) == 0) send_pulse($urandom, LEN_W'($urandom));
      else run_sync_sequence(1'b0);
    end
  endtask

  initial begin
    logic [TIME_W-1:0] t0, t2;
    int unsigned       r_smin, r_lmin;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    s_min    = RST_SHORT_MIN;
    s_max    = RST_SHORT_MAX;
    l_min    = RST_LONG_MIN;
    l_max    = RST_LONG_MAX;
    len_base = RST_LEN_BASE;
    slot_tol = RST_SLOT_TOL;
    send_idle_pct = 14;
    stall_pct     = 67;

    // Length extremes and slot edges while searching
    send_pulse(32'h0000_0000, 16'h0000);
    send_pulse(32'hFFFF_FFFF, 16'hFFFF);
    send_pulse(32'h0000_0010, LEN_W'(len_base - 1));
    send_pulse(32'h0000_0020, LEN_W'(len_base + slot_tol));
    send_pulse(32'h0000_0030, LEN_W'(len_base + (MAX_CODE + 1) * SLOT_TICKS));
    send_pulse(32'h0000_0040, LEN_W'(len_base + MAX_CODE * SLOT_TICKS + slot_tol - 1));
    // Open a sequence, then time it out across the timestamp wrap
    send_pulse(32'h0000_0050, LEN_W'(len_base + 2 * SLOT_TICKS));
    t0 = 32'hFFFF_F000;
    send_pulse(t0, LEN_W'(len_base + slot_tol - 1));
    // Walk the window edges up to the last phase
    send_pulse(t0, LEN_W'(len_base + slot_tol - 1));
    send_pulse(t0 + s_min - 1, LEN_W'(len_base + 4 * SLOT_TICKS));
    send_pulse(t0 + s_min, LEN_W'(len_base + 4 * SLOT_TICKS));
    send_pulse(t0 + l_min - 1, LEN_W'(len_base + SLOT_TICKS));
    t2 = t0 + l_max;
    send_pulse(t2, LEN_W'(len_base + 3 * SLOT_TICKS));
    send_pulse(t2 + s_min, LEN_W'(len_base + 6 * SLOT_TICKS));
    send_pulse(t2 + s_max, LEN_W'(len_base + 5 * SLOT_TICKS + slot_tol));
    // A late invalid word still falls back to searching
    send_pulse(t2 + s_max + 1, LEN_W'(len_base + 5 * SLOT_TICKS + slot_tol));
    // Late in the long window
    t0 = t2 + 32'h0100_0000;
    send_pulse(t0, LEN_W'(len_base + 2 * SLOT_TICKS));
    send_pulse(t0 + s_max, LEN_W'(len_base + 4 * SLOT_TICKS));
    send_pulse(t0 + l_max + 1, LEN_W'(len_base + SLOT_TICKS));
    cur_t = t0 + l_max + 1;

    // Reset settings, with a full drain in the middle
    run_random(220);
    drain_results();
    run_random(230);
    drain_results();

    // Widest short window, zero base, full tolerance
    send_idle_pct = 67;
    stall_pct     = 14;
    set_config(0, 20'hFFFFF, 40000, 60000, 0, SLOT_TICKS);
    run_random(400);
    drain_results();

    // Short window min above max, top base, narrowest tolerance
    send_idle_pct = 0;
    stall_pct     = 0;
    set_config(20'hFFFFF, 0, 0, 20'hFFFFF, 16'hFFFF, 1);
    run_random(250);
    drain_results();

    // Random settings, then one clean sequence that locks
    r_smin = $urandom_range(30000);
    r_lmin = $urandom_range(400000, 50000);
    set_config(r_smin, r_smin + $urandom_range(20000), r_lmin, r_lmin + $urandom_range(50000),
               $urandom_range(60000), $urandom_range(SLOT_TICKS - 1, 1));
    run_random(330);
    run_sync_sequence(1'b1);
    drain_results();

    // Zero tolerance while locked
    set_config(s_min, s_max, l_min, l_max, $urandom_range(65535), 0);
    repeat (20) send_pulse($urandom, LEN_W'($urandom));
    drain_results();

    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
